// ----- src/pagerank_power_iteration_defines.svh -----
// Assertion macros shared by the PageRank power-iteration RTL.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef PAGERANK_POWER_ITERATION_DEFINES_SVH
`define PAGERANK_POWER_ITERATION_DEFINES_SVH

// Checked on every rising edge outside reset.
`define PGR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define PGR_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- src/pgr_pkg.sv -----
// Shared types and constants for the PageRank power-iteration block.
// No dependencies; used by the controller, the datapath and the top level.
package pgr_pkg;

    localparam int VW  = 6;   // vertex number width
    localparam int RW  = 24;  // rank and sum width, Q8.16
    localparam int DMW = 17;  // damping width, Q1.16
    localparam int VCW = 7;   // vertex count register width
    localparam int SCW = 8;   // sweep count register width
    localparam int NV  = 64;  // vertex capacity
    localparam int IN_W  = 16;
    localparam int OUT_W = 32;

    localparam logic [RW-1:0]  RANK_ONE  = 24'd65536;
    localparam logic [RW-1:0]  RANK_MAX  = 24'hFFFFFF;
    localparam logic [DMW-1:0] DAMP_ONE  = 17'd65536;
    localparam logic [VCW-1:0] NV_COUNT  = 7'd64;

    localparam logic [VCW-1:0] VCOUNT_RST = 7'd4;
    localparam logic [DMW-1:0] DAMP_RST   = 17'd32768;
    localparam logic [SCW-1:0] SWEEPS_RST = 8'd4;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_ADD   = 2'd1,
        OP_RUN   = 2'd2,
        OP_READ  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        CFG_VCOUNT = 2'd0,
        CFG_DAMP   = 2'd1,
        CFG_SWEEPS = 2'd2
    } t_cfg_idx;

    localparam logic REPLY_RUN  = 1'b0;
    localparam logic REPLY_RANK = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear;
        logic edge_wr;
        logic drop;
        logic deg_wr;
        logic rank_rd;
        logic sweep_load;
        logic sweep_dec;
        logic sweep_init;
        logic e_fetch;
        logic e_dec;
        logic div_start;
        logic e_acc;
        logic v_init;
        logic v_rd;
        logic v_mul;
        logic v_wr;
        logic out_rd;
        logic out_run;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic edge_ok;
        logic sweeps_zero;
        logic sweeps_last;
        logic edges_done;
        logic verts_done;
        logic skip;
        logic div_done;
        logic out_free;
    } t_sts;

endpackage

// ----- src/pgr_div.sv -----
// Restoring divider, one quotient bit per cycle, for rank / out-degree.
// Depends on pgr_pkg for the rank width.
module pgr_div #(
    parameter int DVW = 11
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [pgr_pkg::RW-1:0] i_dividend,
    input  logic [DVW-1:0]         i_divisor,
    output logic [pgr_pkg::RW-1:0] o_quot,
    output logic                   o_done
);

    localparam int CW = $clog2(pgr_pkg::RW);
    localparam logic [CW-1:0] LAST = CW'(pgr_pkg::RW - 1);

    logic                   r_busy, n_busy;
    logic                   r_done, n_done;
    logic [CW-1:0]          r_cnt, n_cnt;
    logic [DVW-1:0]         r_rem, n_rem;
    logic [pgr_pkg::RW-1:0] r_quo, n_quo;
    logic [DVW-1:0]         r_dvs;
    logic [DVW:0]           trial;
    logic                   fits;

    // One trial subtraction per cycle.
    always_comb begin
        trial  = {r_rem, r_quo[pgr_pkg::RW-1]};
        fits   = trial >= {1'b0, r_dvs};
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_quo  = i_dividend;
        end else if (r_busy) begin
            n_rem = fits ? DVW'(trial - {1'b0, r_dvs}) : trial[DVW-1:0];
            n_quo = {r_quo[pgr_pkg::RW-2:0], fits};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == LAST) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_rem <= n_rem;
        r_quo <= n_quo;
        if (i_start) begin
            r_dvs <= i_divisor;
        end
    end

    assign o_quot = r_quo;
    assign o_done = r_done;

endmodule

// ----- src/pgr_ctrl.sv -----
// Controller state machine: input handshake and sequencing of loads, reads and sweeps.
// Depends on pgr_pkg for the command and status structs.
module pgr_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic [1:0]    i_op,
    input  pgr_pkg::t_sts i_sts,
    output logic          o_in_ready,
    output pgr_pkg::t_cmd o_cmd
);

    typedef enum logic [13:0] {
        S_IDLE    = 14'b00000000000001,
        S_DEG_WR  = 14'b00000000000010,
        S_RD_WAIT = 14'b00000000000100,
        S_SW_INIT = 14'b00000000001000,
        S_E_FETCH = 14'b00000000010000,
        S_E_DEC   = 14'b00000000100000,
        S_E_CHK   = 14'b00000001000000,
        S_E_DIV   = 14'b00000010000000,
        S_E_ACC   = 14'b00000100000000,
        S_V_RD    = 14'b00001000000000,
        S_V_MUL   = 14'b00010000000000,
        S_V_WR    = 14'b00100000000000,
        S_SW_END  = 14'b01000000000000,
        S_FINISH  = 14'b10000000000000
    } t_state;

    t_state r_state, n_state;
    logic   accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    // Next state and command decode.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (pgr_pkg::t_op'(i_op))
                        pgr_pkg::OP_CLEAR: o_cmd.clear = 1'b1;
                        pgr_pkg::OP_ADD: begin
                            if (i_sts.edge_ok) begin
                                o_cmd.edge_wr = 1'b1;
                                n_state = S_DEG_WR;
                            end else begin
                                o_cmd.drop = 1'b1;
                            end
                        end
                        pgr_pkg::OP_RUN: begin
                            o_cmd.sweep_load = 1'b1;
                            n_state = i_sts.sweeps_zero ? S_FINISH : S_SW_INIT;
                        end
                        pgr_pkg::OP_READ: begin
                            o_cmd.rank_rd = 1'b1;
                            n_state = S_RD_WAIT;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_DEG_WR: begin
                o_cmd.deg_wr = 1'b1;
                n_state = S_IDLE;
            end
            S_RD_WAIT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_rd = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_SW_INIT: begin
                o_cmd.sweep_init = 1'b1;
                n_state = S_E_FETCH;
            end
            S_E_FETCH: begin
                if (i_sts.edges_done) begin
                    o_cmd.v_init = 1'b1;
                    n_state = S_V_RD;
                end else begin
                    o_cmd.e_fetch = 1'b1;
                    n_state = S_E_DEC;
                end
            end
            S_E_DEC: begin
                o_cmd.e_dec = 1'b1;
                n_state = S_E_CHK;
            end
            S_E_CHK: begin
                if (i_sts.skip) begin
                    n_state = S_E_FETCH;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state = S_E_DIV;
                end
            end
            S_E_DIV: begin
                if (i_sts.div_done) begin
                    n_state = S_E_ACC;
                end
            end
            S_E_ACC: begin
                o_cmd.e_acc = 1'b1;
                n_state = S_E_FETCH;
            end
            S_V_RD: begin
                if (i_sts.verts_done) begin
                    n_state = S_SW_END;
                end else begin
                    o_cmd.v_rd = 1'b1;
                    n_state = S_V_MUL;
                end
            end
            S_V_MUL: begin
                o_cmd.v_mul = 1'b1;
                n_state = S_V_WR;
            end
            S_V_WR: begin
                o_cmd.v_wr = 1'b1;
                n_state = S_V_RD;
            end
            S_SW_END: begin
                if (i_sts.sweeps_last) begin
                    n_state = S_FINISH;
                end else begin
                    o_cmd.sweep_dec = 1'b1;
                    n_state = S_SW_INIT;
                end
            end
            S_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.out_run = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- src/pgr_dp.sv -----
// Datapath: configuration registers, edge, degree, rank and sum memories, arithmetic
// and the output register. Depends on pgr_pkg, pgr_div and the assertion macros.
`include "pagerank_power_iteration_defines.svh"

module pgr_dp #(
    parameter int MAX_EDGES = 1024
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_wr_en,
    input  logic [1:0]              i_cfg_index,
    input  logic [pgr_pkg::DMW-1:0] i_cfg_wr_data,
    input  logic [pgr_pkg::VW-1:0]  i_src,
    input  logic [pgr_pkg::VW-1:0]  i_tgt,
    input  pgr_pkg::t_cmd           i_cmd,
    input  logic                    i_m_tready,
    output pgr_pkg::t_sts           o_sts,
    output logic                    o_m_tvalid,
    output logic                    o_kind,
    output logic [pgr_pkg::VW-1:0]  o_vertex,
    output logic [pgr_pkg::RW-1:0]  o_rank,
    output logic                    o_error
);

    localparam int ETW = $clog2(MAX_EDGES + 1);
    localparam int EAW = $clog2(MAX_EDGES);
    localparam int VW  = pgr_pkg::VW;
    localparam int RW  = pgr_pkg::RW;
    localparam int NV  = pgr_pkg::NV;
    localparam int PW  = pgr_pkg::DMW + RW;

    // Configuration registers.
    logic [pgr_pkg::VCW-1:0] r_vcount;
    logic [pgr_pkg::DMW-1:0] r_damp;
    logic [pgr_pkg::SCW-1:0] r_sweeps;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount <= pgr_pkg::VCOUNT_RST;
            r_damp   <= pgr_pkg::DAMP_RST;
            r_sweeps <= pgr_pkg::SWEEPS_RST;
        end else if (i_cfg_wr_en) begin
            unique case (pgr_pkg::t_cfg_idx'(i_cfg_index))
                pgr_pkg::CFG_VCOUNT: r_vcount <= i_cfg_wr_data[pgr_pkg::VCW-1:0];
                pgr_pkg::CFG_DAMP:   r_damp   <= i_cfg_wr_data;
                pgr_pkg::CFG_SWEEPS: r_sweeps <= i_cfg_wr_data[pgr_pkg::SCW-1:0];
                default:             r_sweeps <= r_sweeps;
            endcase
        end
    end

    logic [pgr_pkg::VCW-1:0] n_act;
    logic [pgr_pkg::DMW-1:0] d_eff;

    assign n_act = (r_vcount > pgr_pkg::NV_COUNT) ? pgr_pkg::NV_COUNT : r_vcount;
    assign d_eff = (r_damp > pgr_pkg::DAMP_ONE) ? pgr_pkg::DAMP_ONE : r_damp;

    // Control registers: edge count, sticky drop flag, counters, valid bits.
    logic [ETW-1:0]          r_edge_total;
    logic                    r_dropped;
    logic [ETW-1:0]          r_eidx;
    logic [pgr_pkg::VCW-1:0] r_vidx;
    logic [pgr_pkg::SCW-1:0] r_sweeps_left;
    logic [NV-1:0]           r_deg_vld, r_rank_vld, r_sum_vld;
    logic                    r_out_valid;

    // Payload registers.
    logic [VW-1:0]      r_deg_addr;
    logic [VW-1:0]      r_rd_vtx;
    logic [2*VW-1:0]    r_edge;
    logic [ETW-1:0]     r_deg_rd;
    logic               r_deg_rdv;
    logic [RW-1:0]      r_rank_rd;
    logic               r_rank_rdv;
    logic [RW-1:0]      r_sum_rd;
    logic               r_sum_rdv;
    logic [PW-1:0]      r_prod;
    logic               r_kind;
    logic [VW-1:0]      r_out_vtx;
    logic [RW-1:0]      r_out_rank;
    logic               r_out_err;

    // Memories.
    logic [2*VW-1:0] edge_mem [MAX_EDGES];
    logic [ETW-1:0]  deg_mem  [NV];
    logic [RW-1:0]   rank_mem [NV];
    logic [RW-1:0]   sum_mem  [NV];

    logic [VW-1:0]  e_src, e_tgt;
    logic [ETW-1:0] deg_val;
    logic [RW-1:0]  rank_val, sum_val, quot;
    logic           div_done;
    logic [VW-1:0]  deg_raddr, rank_raddr, sum_raddr;
    logic           deg_ren, rank_ren, sum_ren;
    logic [RW:0]    sum_add;
    logic [RW-1:0]  sum_new;
    logic [RW+1:0]  rank_calc;
    logic [RW-1:0]  rank_new;
    logic           out_free;

    assign e_src    = r_edge[2*VW-1:VW];
    assign e_tgt    = r_edge[VW-1:0];
    assign deg_val  = r_deg_rdv ? r_deg_rd : '0;
    assign rank_val = r_rank_rdv ? r_rank_rd : pgr_pkg::RANK_ONE;
    assign sum_val  = r_sum_rdv ? r_sum_rd : '0;

    // Read port selection.
    assign deg_ren    = i_cmd.edge_wr || i_cmd.e_dec;
    assign deg_raddr  = i_cmd.edge_wr ? i_src : e_src;
    assign rank_ren   = i_cmd.rank_rd || i_cmd.e_dec;
    assign rank_raddr = i_cmd.rank_rd ? i_tgt : e_src;
    assign sum_ren    = i_cmd.e_dec || i_cmd.v_rd;
    assign sum_raddr  = i_cmd.e_dec ? e_tgt : r_vidx[VW-1:0];

    // Saturating accumulate and rank update.
    assign sum_add   = {1'b0, sum_val} + {1'b0, quot};
    assign sum_new   = sum_add[RW] ? pgr_pkg::RANK_MAX : sum_add[RW-1:0];
    assign rank_calc = (RW+2)'(pgr_pkg::DAMP_ONE - d_eff) + (RW+2)'(r_prod[PW-1:16]);
    assign rank_new  = (rank_calc > (RW+2)'(pgr_pkg::RANK_MAX)) ? pgr_pkg::RANK_MAX
                                                                : rank_calc[RW-1:0];

    pgr_div #(.DVW(ETW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (rank_val),
        .i_divisor  (deg_val),
        .o_quot     (quot),
        .o_done     (div_done)
    );

    // Control state updates.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge_total  <= '0;
            r_dropped     <= 1'b0;
            r_eidx        <= '0;
            r_vidx        <= '0;
            r_sweeps_left <= '0;
            r_deg_vld     <= '0;
            r_rank_vld    <= '0;
            r_sum_vld     <= '0;
        end else begin
            if (i_cmd.clear) begin
                r_edge_total <= '0;
                r_dropped    <= 1'b0;
                r_deg_vld    <= '0;
                r_rank_vld   <= '0;
                r_sum_vld    <= '0;
            end
            if (i_cmd.drop) begin
                r_dropped <= 1'b1;
            end
            if (i_cmd.edge_wr) begin
                r_edge_total <= r_edge_total + 1'b1;
            end
            if (i_cmd.deg_wr) begin
                r_deg_vld[r_deg_addr] <= 1'b1;
            end
            if (i_cmd.sweep_load) begin
                r_sweeps_left <= r_sweeps;
            end
            if (i_cmd.sweep_dec) begin
                r_sweeps_left <= r_sweeps_left - 1'b1;
            end
            if (i_cmd.sweep_init) begin
                r_sum_vld <= '0;
                r_eidx    <= '0;
            end
            if (i_cmd.e_fetch) begin
                r_eidx <= r_eidx + 1'b1;
            end
            if (i_cmd.e_acc) begin
                r_sum_vld[e_tgt] <= 1'b1;
            end
            if (i_cmd.v_init) begin
                r_vidx <= '0;
            end
            if (i_cmd.v_wr) begin
                r_vidx <= r_vidx + 1'b1;
                r_rank_vld[r_vidx[VW-1:0]] <= 1'b1;
            end
        end
    end

    // Memory writes and registered reads.
    always_ff @(posedge i_clk) begin
        if (i_cmd.edge_wr) begin
            edge_mem[r_edge_total[EAW-1:0]] <= {i_src, i_tgt};
        end
        if (i_cmd.e_fetch) begin
            r_edge <= edge_mem[r_eidx[EAW-1:0]];
        end
        if (i_cmd.deg_wr) begin
            deg_mem[r_deg_addr] <= deg_val + 1'b1;
        end
        if (deg_ren) begin
            r_deg_rd  <= deg_mem[deg_raddr];
            r_deg_rdv <= r_deg_vld[deg_raddr];
        end
        if (i_cmd.v_wr) begin
            rank_mem[r_vidx[VW-1:0]] <= rank_new;
        end
        if (rank_ren) begin
            r_rank_rd  <= rank_mem[rank_raddr];
            r_rank_rdv <= r_rank_vld[rank_raddr];
        end
        if (i_cmd.e_acc) begin
            sum_mem[e_tgt] <= sum_new;
        end
        if (sum_ren) begin
            r_sum_rd  <= sum_mem[sum_raddr];
            r_sum_rdv <= r_sum_vld[sum_raddr];
        end
    end

    // Operand capture and the damping product.
    always_ff @(posedge i_clk) begin
        if (i_cmd.edge_wr) begin
            r_deg_addr <= i_src;
        end
        if (i_cmd.rank_rd) begin
            r_rd_vtx <= i_tgt;
        end
        if (i_cmd.v_mul) begin
            r_prod <= PW'(d_eff) * PW'(sum_val);
        end
    end

    // Output register: one result waits here while the input side goes on.
    assign out_free = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_rd || i_cmd.out_run) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_rd) begin
            r_kind     <= pgr_pkg::REPLY_RANK;
            r_out_vtx  <= r_rd_vtx;
            r_out_rank <= ({1'b0, r_rd_vtx} < n_act) ? rank_val : '0;
            r_out_err  <= r_dropped;
        end else if (i_cmd.out_run) begin
            r_kind     <= pgr_pkg::REPLY_RUN;
            r_out_vtx  <= '0;
            r_out_rank <= '0;
            r_out_err  <= r_dropped;
        end
    end

    // Status back to the controller.
    always_comb begin
        o_sts.edge_ok     = ({1'b0, i_src} < r_vcount) && ({1'b0, i_tgt} < r_vcount)
                            && (r_edge_total < ETW'(MAX_EDGES));
        o_sts.sweeps_zero = (r_sweeps == '0);
        o_sts.sweeps_last = (r_sweeps_left == 8'd1);
        o_sts.edges_done  = (r_eidx == r_edge_total);
        o_sts.verts_done  = (r_vidx == n_act);
        o_sts.skip        = ({1'b0, e_src} >= n_act) || ({1'b0, e_tgt} >= n_act)
                            || (deg_val == '0);
        o_sts.div_done    = div_done;
        o_sts.out_free    = out_free;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_kind     = r_kind;
    assign o_vertex   = r_out_vtx;
    assign o_rank     = r_out_rank;
    assign o_error    = r_out_err;

    // A result is only loaded when the output register can take it.
    `PGR_ASSERT(a_out_free, (i_cmd.out_rd || i_cmd.out_run) |-> (!r_out_valid || i_m_tready), "result loaded over a waiting result")
    // The edge count never passes the store capacity.
    `PGR_ASSERT(a_total_cap, r_edge_total <= ETW'(MAX_EDGES), "edge count beyond capacity")
    // A stored edge advances the count by exactly one.
    `PGR_ASSERT(a_edge_inc, i_cmd.edge_wr |=> (r_edge_total == $past(r_edge_total) + 1'b1), "edge count did not advance")
    // Rank updates only touch vertices in use.
    `PGR_ASSERT(a_vwr_range, i_cmd.v_wr |-> (r_vidx < n_act), "rank write beyond active vertices")

endmodule

// ----- src/pagerank_power_iteration.sv -----
// PageRank power iteration: edges load one per item, a run performs the sweeps.
// Clear empties the graph; add edge stores the edge, then the source's out-degree; read rank
// waits for a free output register. Each sweep accumulates rank / out-degree over kept edges
// (the divider gives one quotient bit per cycle), updates each active vertex, then a run replies.
// Reset is synchronous, active low: registers go to defaults, ranks read as 1.0
// through per-vertex valid bits, so no clearing pass is needed; the edge store is not cleared.
module pagerank_power_iteration #(
    parameter int MAX_EDGES = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_wr_en,
    input  logic [1:0]               i_cfg_index,
    input  logic [pgr_pkg::DMW-1:0]  i_cfg_wr_data,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    // command [1:0], source_vertex [7:2], target_vertex [13:8], zero [15:14]
    input  logic [pgr_pkg::IN_W-1:0] s_axis_tdata,
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // reply_vertex [5:0], rank_value [29:6], error_flag [30], zero [31]
    output logic [pgr_pkg::OUT_W-1:0] m_axis_tdata,
    // reply_kind [0]
    output logic [0:0]               m_axis_tuser
);

    pgr_pkg::t_cmd              cmd;
    pgr_pkg::t_sts              sts;
    logic                       kind;
    logic [pgr_pkg::VW-1:0]     vertex;
    logic [pgr_pkg::RW-1:0]     rank;
    logic                       error;

    pgr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_op       (s_axis_tdata[1:0]),
        .i_sts      (sts),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd)
    );

    pgr_dp #(.MAX_EDGES(MAX_EDGES)) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_src         (s_axis_tdata[7:2]),
        .i_tgt         (s_axis_tdata[13:8]),
        .i_cmd         (cmd),
        .i_m_tready    (m_axis_tready),
        .o_sts         (sts),
        .o_m_tvalid    (m_axis_tvalid),
        .o_kind        (kind),
        .o_vertex      (vertex),
        .o_rank        (rank),
        .o_error       (error)
    );

    // Pack the result transfer.
    assign m_axis_tdata = {1'b0, error, rank, vertex};
    assign m_axis_tuser = kind;

endmodule
